[hdl/rd_pkg.sv]
// shared types and codes for the reversible deque
// no dependencies; used by reversible_deque_top and rd_ram
package rd_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// command codes
	localparam logic [2:0] CMD_POP_FRONT  = 3'd0;
	localparam logic [2:0] CMD_POP_BACK   = 3'd1;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd3;
	localparam logic [2:0] CMD_REVERSE    = 3'd4;
	localparam logic [2:0] CMD_LIST       = 3'd5;

	// result status codes
	localparam logic [1:0] ST_POPPED  = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_LISTED  = 2'd2;
	localparam logic [1:0] ST_REFUSED = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] entry_value;
		logic               last;
	} rsp_t;

endpackage

[hdl/rd_ram.sv]
// entry storage of the reversible deque: one write port, one read port
// read data registered; depends on rd_pkg for its parameter defaults
module rd_ram #(
	parameter int DEPTH      = rd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rd_pkg::DATA_WIDTH_DEF,
	parameter int AW         = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic signed [DATA_WIDTH-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	output logic signed [DATA_WIDTH-1:0] rd_data
);

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/reversible_deque_top.sv]
// top level of the reversible deque: command decode, pointers, list sequencer
// depends on rd_pkg and rd_ram
//
// A double-ended queue of up to DEPTH signed words kept in a circular buffer
// held in one synchronous RAM, with a reverse flag that swaps which physical
// end is the logical front. A command transfer happens at a clock edge where
// start is high and busy is low. Push and reverse keep busy low, so they can
// follow each other every cycle; a push on a full queue returns one refused
// result in the cycle after the transfer. A pop reads the RAM and holds busy
// high for one cycle; its result passes the RAM read register and then the
// output register. A list of n entries holds busy while its reads are in flight
// and streams n results on consecutive cycles through the same two registers,
// the final one marked by last. Pop or list on an empty queue returns one empty
// result in the cycle after the transfer, with no RAM read. Each result is shown
// for exactly one cycle with result_strobe high and cannot be held off; the
// receiver must take it then. No clearing pass is needed after reset.
module reversible_deque_top #(
	parameter int DEPTH      = rd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rd_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  rd_pkg::req_t request,
	output logic        result_strobe,
	output rd_pkg::rsp_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
	localparam logic [AW-1:0] SLOT_LAST  = AW'(DEPTH - 1);

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

	// circular slot arithmetic: base and offset both below DEPTH
	function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
	                                           input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// control state
	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic            rev_q;
	logic [CW-1:0]   idx_q;
	logic            rd_valid_s1;
	logic            strobe_q;

	// read pipeline payload and output register
	logic [1:0]      status_s1;
	logic            last_s1;
	rd_pkg::rsp_t    result_q;

	// decode
	logic            accept;
	logic            is_pop, is_push, is_rev, is_list;
	logic            pop_back, push_tail;
	logic            empty, full;
	logic            direct_fire;
	logic            list_last;

	// slot computation
	logic [AW-1:0]   tail_slot, append_slot, head_dec, head_inc, list_slot;
	logic [CW-1:0]   count_m1, list_off;

	// ram ports
	logic                         wr_en, rd_en;
	logic [AW-1:0]                wr_addr, rd_addr;
	logic signed [DATA_WIDTH-1:0] wr_data, rd_data;
	logic signed [63:0]           rd_ext;
	logic signed [63:0]           push_ext;

	assign busy          = (state_q == S_LIST) || rd_valid_s1;
	assign accept        = start && !busy;
	assign result_strobe = strobe_q;
	assign result        = result_q;

	assign is_pop  = (request.command == rd_pkg::CMD_POP_FRONT) ||
	                 (request.command == rd_pkg::CMD_POP_BACK);
	assign is_push = (request.command == rd_pkg::CMD_PUSH_BACK) ||
	                 (request.command == rd_pkg::CMD_PUSH_FRONT);
	assign is_rev  = (request.command == rd_pkg::CMD_REVERSE);
	assign is_list = (request.command == rd_pkg::CMD_LIST);

	// reversal swaps which physical end is touched
	assign pop_back  = (request.command == rd_pkg::CMD_POP_BACK) ^ rev_q;
	assign push_tail = (request.command == rd_pkg::CMD_PUSH_BACK) ^ rev_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == COUNT_FULL);

	// empty and refused results need no ram read
	assign direct_fire = accept && (((is_pop || is_list) && empty) || (is_push && full));

	assign count_m1    = count_q - CW'(1);
	assign tail_slot   = wrap_slot(head_q, count_m1[AW-1:0]);
	assign append_slot = wrap_slot(head_q, count_q[AW-1:0]);
	assign head_dec    = (head_q == '0) ? SLOT_LAST : head_q - AW'(1);
	assign head_inc    = wrap_slot(head_q, AW'(1));

	// list walks physical order forward, or backward when reversed
	assign list_off  = rev_q ? (count_m1 - idx_q) : idx_q;
	assign list_slot = wrap_slot(head_q, list_off[AW-1:0]);
	assign list_last = (idx_q == count_m1);

	assign push_ext = 64'(request.push_value);
	assign wr_data  = push_ext[DATA_WIDTH-1:0];
	assign rd_ext   = 64'(rd_data);

	// ram access; writes and reads never share a cycle
	always_comb begin
		wr_en   = accept && is_push && !full;
		wr_addr = push_tail ? append_slot : head_dec;
		rd_en   = 1'b0;
		rd_addr = list_slot;
		if (state_q == S_LIST) begin
			rd_en = 1'b1;
		end else if (accept && is_pop && !empty) begin
			rd_en   = 1'b1;
			rd_addr = pop_back ? tail_slot : head_q;
		end
	end

	rd_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer, pointers and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			strobe_q    <= direct_fire || rd_valid_s1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_pop && !empty) begin
							if (!pop_back) begin
								head_q <= head_inc;
							end
							count_q <= count_m1;
						end else if (is_push && !full) begin
							if (!push_tail) begin
								head_q <= head_dec;
							end
							count_q <= count_q + CW'(1);
						end else if (is_rev) begin
							rev_q <= !rev_q;
						end else if (is_list && !empty) begin
							idx_q   <= '0;
							state_q <= S_LIST;
						end
					end
				end
				S_LIST: begin
					idx_q <= idx_q + CW'(1);
					if (list_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			status_s1 <= (state_q == S_LIST) ? rd_pkg::ST_LISTED : rd_pkg::ST_POPPED;
			last_s1   <= (state_q == S_LIST) ? list_last : 1'b1;
		end
		if (rd_valid_s1) begin
			result_q.status      <= status_s1;
			result_q.entry_value <= rd_ext[31:0];
			result_q.last        <= last_s1;
		end else if (direct_fire) begin
			result_q.status      <= is_push ? rd_pkg::ST_REFUSED : rd_pkg::ST_EMPTY;
			result_q.entry_value <= '0;
			result_q.last        <= 1'b1;
		end
	end

	// fill level never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("entry count above capacity");

	// a pop on a non-empty queue delivers a popped result marked last
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pop && !empty) |-> ##2 (result_strobe && result.last &&
		result.status == rd_pkg::ST_POPPED))
		else $error("pop result missing");

	// a list stream has no gaps until its last result
	a_list_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last) |=> result_strobe)
		else $error("gap in list stream");

	// an accepted push on a non-full queue grows it by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the queue");

endmodule

[bench/tb_reversible_deque_top.sv]
// self-checking bench for reversible_deque_top: directed corner cases and random traffic
// depends on rd_pkg and the reversible_deque_top rtl; a class mirrors the deque and checks results
`timescale 1ns / 1ps

module tb_reversible_deque_top;
	import rd_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;

	// mirror of the deque: circular slots, front pointer, fill level, reverse flag
	class deque_tracker;
		rsp_t               due[$];
		logic signed [31:0] slots[SLOTS];
		int                 head;
		int                 count;
		bit                 rev;
		int                 errors;

		function new();
			head   = 0;
			count  = 0;
			rev    = 0;
			errors = 0;
		endfunction

		function void add_due(logic [1:0] st, logic signed [31:0] val, logic fin);
			rsp_t r;
			r.status      = st;
			r.entry_value = val;
			r.last        = fin;
			due.insert(due.size(), r);
		endfunction

		// called on each accepted command transfer
		function void take_command(req_t req);
			bit at_back;
			int off;
			case (req.command)
				CMD_POP_FRONT, CMD_POP_BACK: begin
					at_back = (req.command == CMD_POP_BACK) != rev;
					if (count == 0) begin
						add_due(ST_EMPTY, '0, 1'b1);
					end else if (at_back) begin
						add_due(ST_POPPED, slots[(head + count - 1) % SLOTS], 1'b1);
						count--;
					end else begin
						add_due(ST_POPPED, slots[head], 1'b1);
						head = (head + 1) % SLOTS;
						count--;
					end
				end
				CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
					at_back = (req.command == CMD_PUSH_BACK) != rev;
					if (count >= SLOTS) begin
						add_due(ST_REFUSED, '0, 1'b1);
					end else if (at_back) begin
						slots[(head + count) % SLOTS] = req.push_value;
						count++;
					end else begin
						head = (head + SLOTS - 1) % SLOTS;
						slots[head] = req.push_value;
						count++;
					end
				end
				CMD_REVERSE: rev = !rev;
				CMD_LIST: begin
					if (count == 0) begin
						add_due(ST_EMPTY, '0, 1'b1);
					end else begin
						for (int i = 0; i < count; i++) begin
							off = rev ? count - 1 - i : i;
							add_due(ST_LISTED, slots[(head + off) % SLOTS], i == count - 1);
						end
					end
				end
				default: ; // unused codes do nothing
			endcase
		endfunction

		// called on each result transfer
		function void check_result(rsp_t got);
			rsp_t want;
			if (due.size() == 0) begin
				$error("unexpected result: status %0d entry_value %0d last %0d",
					got.status, got.entry_value, got.last);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.entry_value !== want.entry_value) begin
				$error("entry_value: expected %0d, actual %0d", want.entry_value,
					got.entry_value);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic result_strobe;
	rsp_t result;

	deque_tracker tracker;
	int           cycles = 0;
	int           calm_left = 0; // items left in the current stretch without gaps

	always #1 clk = ~clk;

	reversible_deque_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.result_strobe (result_strobe),
		.result        (result)
	);

	// watchdog: a hung handshake or missing result ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// results cannot be held off, so every strobed cycle is a transfer
	always @(posedge clk) begin
		if (arst_n && result_strobe)
			tracker.check_result(result);
	end

	// values lean on the extremes now and then, otherwise fully random bits
	function automatic logic [31:0] draw_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// mode 0 mixed, 1 push-heavy, 2 pop-heavy
	function automatic logic [2:0] draw_command(int mode);
		int roll;
		int push_lim;
		int pop_lim;
		roll = $urandom_range(0, 99);
		push_lim = (mode == 1) ? 65 : (mode == 2) ? 20 : 40;
		pop_lim  = (mode == 1) ? 78 : (mode == 2) ? 75 : 75;
		if (roll < push_lim)
			return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		else if (roll < pop_lim)
			return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
		else if (roll < 86)
			return CMD_REVERSE;
		else if (roll < 96)
			return CMD_LIST;
		else
			return 3'($urandom_range(6, 7)); // unused codes
	endfunction

	// one command transfer: optional gap, then hold start until busy is low at an edge
	task automatic issue(input logic [2:0] cmd, input logic [31:0] value);
		int   gap;
		req_t req;
		req.command    = cmd;
		req.push_value = value;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				calm_left = $urandom_range(5, 20);
			gap = $urandom_range(0, 16);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		tracker.take_command(req);
	endtask

	task automatic random_run(input int items);
		int mode;
		mode = 0;
		for (int i = 0; i < items; i++) begin
			if (i % 20 == 0)
				mode = $urandom_range(0, 2);
			issue(draw_command(mode), draw_value());
		end
	endtask

	initial begin
		tracker = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: both pops and a list report empty
		issue(CMD_POP_FRONT, 32'h0);
		issue(CMD_POP_BACK, 32'h0);
		issue(CMD_LIST, 32'h0);
		// extremes at both ends
		issue(CMD_PUSH_BACK, 32'h7fff_ffff);
		issue(CMD_PUSH_FRONT, 32'h8000_0000);
		issue(CMD_PUSH_BACK, 32'h0000_0000);
		issue(CMD_PUSH_FRONT, 32'hffff_ffff);
		issue(CMD_LIST, 32'h0);
		// reversed order: ends swap
		issue(CMD_REVERSE, 32'h0);
		issue(CMD_LIST, 32'h0);
		issue(CMD_POP_FRONT, 32'h0);
		issue(CMD_POP_BACK, 32'h0);
		issue(CMD_PUSH_FRONT, 32'h5a5a_5a5a);
		issue(CMD_PUSH_BACK, 32'ha5a5_a5a5);
		issue(CMD_LIST, 32'h0);
		// unused codes are ignored
		issue(3'd6, 32'h1234_5678);
		issue(3'd7, 32'hdead_beef);
		issue(CMD_REVERSE, 32'h0);
		issue(CMD_POP_FRONT, 32'h0);
		issue(CMD_POP_BACK, 32'h0);
		issue(CMD_POP_BACK, 32'h0);
		issue(CMD_LIST, 32'h0);
		issue(CMD_POP_FRONT, 32'h0);
		issue(CMD_POP_FRONT, 32'h0);

		random_run(10);

		// fill to capacity, hit the refused-push case at both ends, list full queue
		while (tracker.count < SLOTS)
			issue($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, draw_value());
		issue(CMD_PUSH_BACK, draw_value());
		issue(CMD_PUSH_FRONT, draw_value());
		issue(CMD_LIST, 32'h0);
		issue(CMD_REVERSE, 32'h0);
		issue(CMD_LIST, 32'h0);

		random_run(10);

		start <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[reversible_deque_top.f]
hdl/rd_pkg.sv
hdl/rd_ram.sv
hdl/reversible_deque_top.sv
bench/tb_reversible_deque_top.sv
